// ===== src/ifg_pkg.sv =====
// ----------------------------------------------------------------------------
// ifg_pkg: shared types and constants of the IDR frame gate
// Verdict codes, register indexes, start code constants and the structs
// that pass between the gate's modules.
// ----------------------------------------------------------------------------
package ifg_pkg;

    localparam int BYTE_W    = 8;
    localparam int STREAM_W  = 4;
    localparam int COUNT_W   = 8;
    localparam int REG_IDX_W = 2;
    localparam int CFG_W     = 8;
    localparam int OUT_W     = 8;

    localparam logic [23:0] START_CODE    = 24'h000001;
    localparam logic [4:0]  NAL_TYPE_MASK = 5'h1f;
    localparam logic [4:0]  NAL_TYPE_IDR  = 5'd5;

    localparam logic [REG_IDX_W-1:0] REG_ENABLE   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_IDR_ONLY = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SKIP     = 2'd2;

    typedef enum logic [2:0] {
        VERDICT_FORWARD   = 3'd0,
        VERDICT_IGNORED   = 3'd1,
        VERDICT_AWAIT     = 3'd2,
        VERDICT_NOT_IDR   = 3'd3,
        VERDICT_DECIMATED = 3'd4
    } verdict_t;

    // one frame result
    typedef struct packed {
        verdict_t verdict;
        logic     frame_is_idr;
        logic     forward;
    } result_t;

    // status of the phase recompute unit
    typedef struct packed {
        logic               busy;
        logic               done;
        logic [COUNT_W-1:0] remainder;
    } div_status_t;

endpackage

// ===== src/ifg_nal_scan.sv =====
// ----------------------------------------------------------------------------
// ifg_nal_scan: start code and IDR header search
// Tracks the last three bytes of the frame and flags an IDR NAL header
// once a further byte of the same frame confirms it.
// ----------------------------------------------------------------------------
module ifg_nal_scan
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [ifg_pkg::BYTE_W-1:0] data_byte,
    input  logic                       last_byte,
    output logic                       frame_is_idr
);

    logic [23:0] recent_reg,  recent_next;
    logic [1:0]  count_reg,   count_next;
    logic        pending_reg, pending_next;
    logic        seen_reg,    seen_next;
    logic        is_header;

    // a header pending from the previous byte is confirmed by this one
    assign frame_is_idr = seen_reg | pending_reg;
    assign is_header    = (count_reg == 2'd3) && (recent_reg == ifg_pkg::START_CODE);

    always_comb
    begin
        recent_next  = recent_reg;
        count_next   = count_reg;
        pending_next = pending_reg;
        seen_next    = seen_reg;
        if (accept)
        begin
            if (last_byte)
            begin
                recent_next  = '0;
                count_next   = '0;
                pending_next = 1'b0;
                seen_next    = 1'b0;
            end
            else
            begin
                seen_next    = frame_is_idr;
                pending_next = is_header &&
                    ((data_byte[4:0] & ifg_pkg::NAL_TYPE_MASK) == ifg_pkg::NAL_TYPE_IDR);
                recent_next  = {recent_reg[15:0], data_byte};
                if (count_reg != 2'd3)
                begin
                    count_next = count_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg  <= '0;
            count_reg   <= '0;
            pending_reg <= 1'b0;
            seen_reg    <= 1'b0;
        end
        else
        begin
            recent_reg  <= recent_next;
            count_reg   <= count_next;
            pending_reg <= pending_next;
            seen_reg    <= seen_next;
        end
    end

endmodule

// ===== src/ifg_phase_div.sv =====
// ----------------------------------------------------------------------------
// ifg_phase_div: thinning phase recompute
// Restoring remainder, one dividend bit per cycle: gives the thinning
// counter modulo skip_count+1 after skip_count is rewritten.
// ----------------------------------------------------------------------------
module ifg_phase_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ifg_pkg::COUNT_W-1:0] dividend,
    input  logic [ifg_pkg::CFG_W-1:0]   skip_count,
    output ifg_pkg::div_status_t        status
);

    localparam int STEP_W = $clog2(ifg_pkg::COUNT_W);

    logic [ifg_pkg::COUNT_W-1:0] rem_reg,  rem_next;
    logic [ifg_pkg::COUNT_W-1:0] dvd_reg,  dvd_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic                        busy_reg, busy_next;
    logic [ifg_pkg::COUNT_W:0]   modulus;
    logic [ifg_pkg::COUNT_W:0]   trial;
    logic [ifg_pkg::COUNT_W-1:0] rem_step;

    assign modulus = {1'b0, skip_count} + {{ifg_pkg::COUNT_W{1'b0}}, 1'b1};
    assign trial   = {rem_reg, dvd_reg[ifg_pkg::COUNT_W-1]};

    always_comb
    begin
        if (trial >= modulus)
        begin
            rem_step = ifg_pkg::COUNT_W'(trial - modulus);
        end
        else
        begin
            rem_step = trial[ifg_pkg::COUNT_W-1:0];
        end
    end

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            dvd_next  = dividend;
            step_next = STEP_W'(ifg_pkg::COUNT_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = rem_step;
            dvd_next = {dvd_reg[ifg_pkg::COUNT_W-2:0], 1'b0};
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                step_next = step_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
    end

    assign status.busy      = busy_reg;
    assign status.done      = busy_reg && (step_reg == '0) && !start;
    assign status.remainder = rem_step;

endmodule

// ===== src/ifg_verdict.sv =====
// ----------------------------------------------------------------------------
// ifg_verdict: frame verdict and decimation
// Decides each frame at its last byte and keeps the first-IDR flag, the
// thinning counter and its phase modulo skip_count+1.
// ----------------------------------------------------------------------------
module ifg_verdict
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         frame_end,
    input  logic [ifg_pkg::STREAM_W-1:0] stream_id,
    input  logic                         frame_is_idr,
    input  logic                         enable,
    input  logic                         idr_only,
    input  logic [ifg_pkg::CFG_W-1:0]    skip_count,
    input  ifg_pkg::div_status_t         div_status,
    output logic [ifg_pkg::COUNT_W-1:0]  thinning_count,
    output ifg_pkg::result_t             result
);

    logic                        awaiting_reg, awaiting_next;
    logic [ifg_pkg::COUNT_W-1:0] count_reg,    count_next;
    logic [ifg_pkg::COUNT_W-1:0] phase_reg,    phase_next;
    ifg_pkg::verdict_t           verdict;

    always_comb
    begin
        awaiting_next = awaiting_reg;
        count_next    = count_reg;
        phase_next    = phase_reg;
        verdict       = ifg_pkg::VERDICT_FORWARD;
        if (div_status.done)
        begin
            phase_next = div_status.remainder;
        end
        if ((stream_id != '0) || !enable)
        begin
            verdict = ifg_pkg::VERDICT_IGNORED;
        end
        else if (awaiting_reg && !frame_is_idr)
        begin
            verdict = ifg_pkg::VERDICT_AWAIT;
        end
        else
        begin
            if (frame_end)
            begin
                awaiting_next = 1'b0;
            end
            if (idr_only && !frame_is_idr)
            begin
                verdict = ifg_pkg::VERDICT_NOT_IDR;
            end
            else if ((skip_count != '0) && !idr_only)
            begin
                verdict = (phase_reg == '0) ? ifg_pkg::VERDICT_FORWARD
                                            : ifg_pkg::VERDICT_DECIMATED;
                if (frame_end)
                begin
                    count_next = count_reg + ifg_pkg::COUNT_W'(1);
                    // wrap to zero restarts the phase; otherwise step mod skip+1
                    if ((count_reg == '1) || (phase_reg == skip_count))
                    begin
                        phase_next = '0;
                    end
                    else
                    begin
                        phase_next = phase_reg + ifg_pkg::COUNT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg <= 1'b1;
            count_reg    <= '0;
            phase_reg    <= '0;
        end
        else
        begin
            awaiting_reg <= awaiting_next;
            count_reg    <= count_next;
            phase_reg    <= phase_next;
        end
    end

    assign thinning_count      = count_reg;
    assign result.verdict      = verdict;
    assign result.frame_is_idr = frame_is_idr;
    assign result.forward      = (verdict == ifg_pkg::VERDICT_FORWARD);

endmodule

// ===== src/ifg_out_reg.sv =====
// ----------------------------------------------------------------------------
// ifg_out_reg: result register
// Holds one frame result until the downstream side takes it.
// ----------------------------------------------------------------------------
module ifg_out_reg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  ifg_pkg::result_t result,
    input  logic             take,
    output logic             valid,
    output ifg_pkg::result_t held
);

    logic             valid_reg, valid_next;
    ifg_pkg::result_t held_reg;

    assign valid_next = load | (valid_reg & !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            held_reg <= result;
        end
    end

    assign valid = valid_reg;
    assign held  = held_reg;

endmodule

// ===== src/h264_idr_frame_gate.sv =====
// ----------------------------------------------------------------------------
// h264_idr_frame_gate: IDR detect and frame decimation gate
// Scans Annex B frame bytes for an IDR NAL header and gives one verdict
// word per frame at its last byte.
// ----------------------------------------------------------------------------
//  channel   direction  word                                      accepted on
//  s_axis    in         tdata: data_byte; tuser: stream_id;        tvalid & tready
//                       tlast: last_byte
//  m_axis    out        tdata: forward, frame_is_idr, verdict      tvalid & tready
//  cfg       in         index 0 enable, 1 idr_only, 2 skip_count   valid & ready
//
//  One byte per cycle while s_axis_tready is high; a frame's verdict is registered
//  at its last byte and shows on m_axis the next cycle.
//  A write of skip_count starts a remainder pass (one bit a cycle) that
//  recomputes the thinning phase; s_axis_tready is low during it.
//  s_axis_tready also drops while a verdict waits and m_axis_tready is low.
//  Reset clears the cfg registers and arms await-IDR; cfg_ready is always high.
// ----------------------------------------------------------------------------
module h264_idr_frame_gate
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
    input  logic [3:0]                    s_axis_tuser,  // [3:0] stream_id
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [0] forward, [1] frame_is_idr, [4:2] verdict, [7:5] zero
    output logic [ifg_pkg::OUT_W-1:0]     m_axis_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ifg_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [ifg_pkg::CFG_W-1:0]     cfg_data
);

    logic                        enable_reg;
    logic                        idr_only_reg;
    logic [ifg_pkg::CFG_W-1:0]   skip_reg;
    logic                        cfg_write;
    logic                        skip_write;
    logic                        in_accept;
    logic                        frame_end;
    logic                        frame_is_idr;
    logic [ifg_pkg::COUNT_W-1:0] thinning_count;
    ifg_pkg::div_status_t        div_status;
    ifg_pkg::result_t            result;
    ifg_pkg::result_t            held;

    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid & cfg_ready;
    assign skip_write = cfg_write && (cfg_index == ifg_pkg::REG_SKIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b0;
            idr_only_reg <= 1'b0;
            skip_reg     <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == ifg_pkg::REG_ENABLE)
            begin
                enable_reg <= cfg_data[0];
            end
            if (cfg_index == ifg_pkg::REG_IDR_ONLY)
            begin
                idr_only_reg <= cfg_data[0];
            end
            if (cfg_index == ifg_pkg::REG_SKIP)
            begin
                skip_reg <= cfg_data;
            end
        end
    end

    // hold input while the phase pass runs or a verdict is still unclaimed
    assign s_axis_tready = !div_status.busy && (!m_axis_tvalid || m_axis_tready);
    assign in_accept     = s_axis_tvalid & s_axis_tready;
    assign frame_end     = in_accept & s_axis_tlast;

    ifg_nal_scan u_scan
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_accept),
        .data_byte    (s_axis_tdata),
        .last_byte    (s_axis_tlast),
        .frame_is_idr (frame_is_idr)
    );

    ifg_phase_div u_div
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (skip_write),
        .dividend   (thinning_count),
        .skip_count (cfg_data),
        .status     (div_status)
    );

    ifg_verdict u_verdict
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .frame_end      (frame_end),
        .stream_id      (s_axis_tuser),
        .frame_is_idr   (frame_is_idr),
        .enable         (enable_reg),
        .idr_only       (idr_only_reg),
        .skip_count     (skip_reg),
        .div_status     (div_status),
        .thinning_count (thinning_count),
        .result         (result)
    );

    ifg_out_reg u_out
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (frame_end),
        .result (result),
        .take   (m_axis_tready),
        .valid  (m_axis_tvalid),
        .held   (held)
    );

    assign m_axis_tdata = {3'b000, held.verdict, held.frame_is_idr, held.forward};

    a_ready_low_in_pass : assert property (@(posedge clk) disable iff (!rst_n)
        div_status.busy |-> !s_axis_tready)
        else $error("input taken during phase recompute");

    a_frame_end_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
        frame_end |=> m_axis_tvalid)
        else $error("frame end left no result");

    a_forward_matches_verdict : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] ==
            (m_axis_tdata[4:2] == ifg_pkg::VERDICT_FORWARD)))
        else $error("forward flag disagrees with verdict");

endmodule

// ===== bench/tb_h264_idr_frame_gate.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_h264_idr_frame_gate: self-checking bench for the IDR frame gate
// Streams Annex B frame bytes with random bursts and gaps and runs a scoreboard
// that recomputes each frame verdict. The frame byte stream is checked against
// a cycle-free predictor while the verdict port stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_h264_idr_frame_gate;

    localparam int RUN_LIMIT    = 400000;
    localparam int IDLE_CYCLES  = 20;
    localparam int CFG_SETTLE   = 12;
    localparam int HOLD_CYCLES  = 500;
    localparam int PHASE_BYTES  = 215;
    localparam int MAX_PRINTS   = 50;
    localparam logic [ifg_pkg::REG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_HALF,
        RX_SPARSE,
        RX_PATTERN
    } rx_mode_t;

    typedef struct packed {
        logic [7:0] data;
        logic [3:0] stream;
        logic       last;
    } byte_item_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [7:0]                    s_axis_tdata = '0;   // [7:0] data_byte
    logic [3:0]                    s_axis_tuser = '0;   // [3:0] stream_id
    logic                          s_axis_tlast = 1'b0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    // [0] forward, [1] frame_is_idr, [4:2] verdict
    logic [ifg_pkg::OUT_W-1:0]     m_axis_tdata;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [ifg_pkg::REG_IDX_W-1:0] cfg_index = '0;
    logic [ifg_pkg::CFG_W-1:0]     cfg_data = '0;

    // stimulus and scoreboard storage
    byte_item_t       pending_bytes[$];
    logic [7:0]       frame_buf[$];
    ifg_pkg::result_t verdict_queue[$];

    int bytes_queued   = 0;
    int bytes_accepted = 0;
    int frames_checked = 0;
    int idr_frames     = 0;
    int error_count    = 0;
    int phases_run     = 0;
    int cycle_count    = 0;
    int verdict_hits[5];

    // predictor copy of the gate
    logic        gate_enable     = 1'b0;
    logic        gate_idr_only   = 1'b0;
    logic [7:0]  gate_skip       = '0;
    logic [23:0] win_bytes       = '0;
    logic [1:0]  win_fill        = '0;
    logic        hdr_pending     = 1'b0;
    logic        frame_has_idr   = 1'b0;
    logic        await_first_idr = 1'b1;
    logic [7:0]  thin_count      = '0;

    // traffic shaping
    int       burst_left = 0;
    int       gap_left   = 0;
    rx_mode_t rx_mode    = RX_OPEN;
    int       mode_left  = 0;
    logic     hold_armed = 1'b0;
    logic     hold_done  = 1'b0;
    int       hold_left  = 0;

    h264_idr_frame_gate dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_PRINTS)
        begin
            $display("MISMATCH at %0t: %s", $time, what);
        end
    endtask

    // Scan one accepted byte; at a frame end, push the verdict the gate owes.
    task automatic gate_scan_byte(input logic [7:0] data, input logic [3:0] stream,
                                  input logic last);
        logic             is_header;
        logic [8:0]       modulus;
        ifg_pkg::result_t res;
        // a header byte is only confirmed once another byte of the frame follows
        if (hdr_pending)
        begin
            frame_has_idr = 1'b1;
        end
        is_header   = (win_fill == 2'd3) && (win_bytes == ifg_pkg::START_CODE);
        hdr_pending = is_header &&
            ((data[4:0] & ifg_pkg::NAL_TYPE_MASK) == ifg_pkg::NAL_TYPE_IDR);
        win_bytes   = {win_bytes[15:0], data};
        if (win_fill != 2'd3)
        begin
            win_fill = win_fill + 2'd1;
        end
        if (last)
        begin
            res.frame_is_idr = frame_has_idr;
            if (stream != '0 || !gate_enable)
            begin
                res.verdict = ifg_pkg::VERDICT_IGNORED;
            end
            else if (await_first_idr && !frame_has_idr)
            begin
                res.verdict = ifg_pkg::VERDICT_AWAIT;
            end
            else
            begin
                await_first_idr = 1'b0;
                if (gate_idr_only && !frame_has_idr)
                begin
                    res.verdict = ifg_pkg::VERDICT_NOT_IDR;
                end
                else if (gate_skip != '0 && !gate_idr_only)
                begin
                    modulus     = {1'b0, gate_skip} + 9'd1;
                    res.verdict = (({1'b0, thin_count} % modulus) == 9'd0) ?
                                  ifg_pkg::VERDICT_FORWARD : ifg_pkg::VERDICT_DECIMATED;
                    thin_count  = thin_count + 8'd1;
                end
                else
                begin
                    res.verdict = ifg_pkg::VERDICT_FORWARD;
                end
            end
            res.forward = (res.verdict == ifg_pkg::VERDICT_FORWARD);
            verdict_queue.push_back(res);
            win_bytes     = '0;
            win_fill      = '0;
            hdr_pending   = 1'b0;
            frame_has_idr = 1'b0;
        end
    endtask

    // Sender: bursts of random length, random gaps, hold while stalled.
    always @(posedge clk)
    begin : drive_proc
        byte_item_t item;
        if (rst_n && (!s_axis_tvalid || s_axis_tready))
        begin
            if (gap_left != 0)
            begin
                gap_left      <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_bytes.size() != 0)
            begin
                item = pending_bytes.pop_front();
                s_axis_tdata  <= item.data;
                s_axis_tuser  <= item.stream;
                s_axis_tlast  <= item.last;
                s_axis_tvalid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, started once by the stimulus.
    always @(posedge clk)
    begin
        if (hold_armed && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: stall pattern switches at random among open, half, sparse and patterned modes.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode   <= rx_mode_t'($urandom_range(0, 3));
                mode_left <= $urandom_range(20, 120);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            if (hold_left != 0)
            begin
                m_axis_tready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_OPEN:    m_axis_tready <= 1'b1;
                    RX_HALF:    m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:  m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default:    m_axis_tready <= (cycle_count[2:0] != 3'd3);
                endcase
            end
        end
    end

    // Monitor: track register writes, predict on accepted bytes, check verdicts.
    always @(posedge clk)
    begin : monitor_proc
        ifg_pkg::result_t want;
        logic [2:0]       got_verdict;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_verdict = m_axis_tdata[4:2];
            frames_checked++;
            if (got_verdict <= ifg_pkg::VERDICT_DECIMATED)
            begin
                verdict_hits[got_verdict]++;
            end
            if (m_axis_tdata[1])
            begin
                idr_frames++;
            end
            if (verdict_queue.size() == 0)
            begin
                report_mismatch($sformatf("unexpected verdict word %02h", m_axis_tdata));
            end
            else
            begin
                want = verdict_queue.pop_front();
                if (m_axis_tdata[0] !== want.forward)
                begin
                    report_mismatch($sformatf("frame %0d forward %b, want %b",
                        frames_checked, m_axis_tdata[0], want.forward));
                end
                if (m_axis_tdata[1] !== want.frame_is_idr)
                begin
                    report_mismatch($sformatf("frame %0d frame_is_idr %b, want %b",
                        frames_checked, m_axis_tdata[1], want.frame_is_idr));
                end
                if (got_verdict !== want.verdict)
                begin
                    report_mismatch($sformatf("frame %0d verdict %0d, want %0d",
                        frames_checked, got_verdict, want.verdict));
                end
                if (m_axis_tdata[7:5] !== 3'b000)
                begin
                    report_mismatch($sformatf("frame %0d pad bits %b not zero",
                        frames_checked, m_axis_tdata[7:5]));
                end
            end
        end
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ifg_pkg::REG_ENABLE:   gate_enable   = cfg_data[0];
                ifg_pkg::REG_IDR_ONLY: gate_idr_only = cfg_data[0];
                ifg_pkg::REG_SKIP:     gate_skip     = cfg_data;
                default:               ;
            endcase
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            gate_scan_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast);
            bytes_accepted++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("timeout after %0d cycles", RUN_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(input logic [ifg_pkg::REG_IDX_W-1:0] idx,
                             input logic [ifg_pkg::CFG_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        // a skip write starts the remainder pass; let it finish
        repeat (CFG_SETTLE) @(posedge clk);
    endtask

    task automatic commit_frame(input logic [3:0] stream);
        byte_item_t item;
        foreach (frame_buf[i])
        begin
            item.data   = frame_buf[i];
            item.stream = stream;
            item.last   = (i == frame_buf.size() - 1);
            pending_bytes.push_back(item);
        end
        bytes_queued += frame_buf.size();
        frame_buf.delete();
    endtask

    task automatic wait_idle();
        while (bytes_accepted != bytes_queued || verdict_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (IDLE_CYCLES) @(posedge clk);
    endtask

    // Mostly well-formed start code + header frames, some broken and noise frames.
    task automatic queue_random_frame();
        int         kind;
        int         tail;
        logic [2:0] hdr_hi;
        logic [4:0] hdr_type;
        logic [3:0] stream;
        kind   = $urandom_range(0, 9);
        tail   = $urandom_range(0, 6);
        hdr_hi = 3'($urandom_range(0, 7));
        repeat ($urandom_range(0, 3)) frame_buf.push_back(8'($urandom_range(0, 255)));
        if (kind <= 6)
        begin
            if ($urandom_range(0, 1))
            begin
                frame_buf.push_back(8'h00);
            end
            frame_buf.push_back(8'h00);
            frame_buf.push_back(8'h00);
            frame_buf.push_back(8'h01);
            if (kind <= 4)
            begin
                frame_buf.push_back({hdr_hi, ifg_pkg::NAL_TYPE_IDR});
                // drop the tail now and then so the header lands on the last byte
                if (kind == 0)
                begin
                    tail = 0;
                end
            end
            else
            begin
                do
                    hdr_type = 5'($urandom_range(0, 31));
                while (hdr_type == ifg_pkg::NAL_TYPE_IDR);
                frame_buf.push_back({hdr_hi, hdr_type});
            end
        end
        else if (kind == 7)
        begin
            // near-miss start code ahead of an IDR-looking byte
            frame_buf.push_back(8'h00);
            frame_buf.push_back($urandom_range(0, 1) ? 8'h01 : 8'h02);
            frame_buf.push_back({hdr_hi, ifg_pkg::NAL_TYPE_IDR});
        end
        repeat (tail) frame_buf.push_back(8'($urandom_range(0, 255)));
        if (frame_buf.size() == 0)
        begin
            frame_buf.push_back(8'($urandom_range(0, 255)));
        end
        stream = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(1, 15)) : 4'd0;
        commit_frame(stream);
    endtask

    task automatic run_phase(input logic [ifg_pkg::CFG_W-1:0] en_val,
                             input logic [ifg_pkg::CFG_W-1:0] idr_val,
                             input logic [ifg_pkg::CFG_W-1:0] skip_val,
                             input logic with_hold);
        int target;
        write_reg(ifg_pkg::REG_ENABLE, en_val);
        write_reg(ifg_pkg::REG_IDR_ONLY, idr_val);
        write_reg(ifg_pkg::REG_SKIP, skip_val);
        target = bytes_queued + PHASE_BYTES;
        while (bytes_queued < target)
        begin
            queue_random_frame();
        end
        if (with_hold)
        begin
            hold_armed = 1'b1;
        end
        wait_idle();
        phases_run++;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // gate still disabled after reset: an IDR frame is ignored
        frame_buf = '{8'h00, 8'h00, 8'h01, 8'h65, 8'hFF};
        commit_frame(4'd0);
        wait_idle();

        write_reg(ifg_pkg::REG_ENABLE, 8'hA5);
        write_reg(ifg_pkg::REG_IDR_ONLY, 8'h00);
        write_reg(ifg_pkg::REG_SKIP, 8'h00);
        // no IDR yet: plain frame waits for the first IDR
        frame_buf = '{8'h12, 8'h34};
        commit_frame(4'd0);
        // IDR header on the frame's last byte does not count
        frame_buf = '{8'h00, 8'h00, 8'h01, 8'h25};
        commit_frame(4'd0);
        // other stream: ignored, search result still reported
        frame_buf = '{8'h00, 8'h00, 8'h01, 8'h05, 8'h00};
        commit_frame(4'd15);
        // four-byte start code opens the gate
        frame_buf = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h45, 8'h00};
        commit_frame(4'd0);
        frame_buf = '{8'hFF};
        commit_frame(4'd0);
        wait_idle();
        phases_run++;

        run_phase(8'h01, 8'h00, 8'h00, 1'b0);
        run_phase(8'hFF, 8'hFE, 8'hFF, 1'b1);
        run_phase(8'h01, 8'h01, 8'h07, 1'b0);
        run_phase(8'hFE, 8'h00, 8'h03, 1'b0);
        write_reg(REG_UNUSED, 8'hFF);
        run_phase(8'h01, 8'h00, 8'h01, 1'b0);
        run_phase(8'h01, 8'h80, ifg_pkg::CFG_W'($urandom_range(2, 254)), 1'b0);
        run_phase(8'h01, 8'h81, 8'h00, 1'b0);
        run_phase(8'h01, 8'h00, 8'h02, 1'b0);

        $display("Covered %0d bytes, %0d frame verdicts (%0d IDR) over %0d gate settings.",
                 bytes_accepted, frames_checked, idr_frames, phases_run);
        $display("Verdicts: forwarded %0d, ignored %0d, awaiting IDR %0d, not IDR %0d, %s %0d.",
                 verdict_hits[ifg_pkg::VERDICT_FORWARD],
                 verdict_hits[ifg_pkg::VERDICT_IGNORED],
                 verdict_hits[ifg_pkg::VERDICT_AWAIT],
                 verdict_hits[ifg_pkg::VERDICT_NOT_IDR],
                 "decimated", verdict_hits[ifg_pkg::VERDICT_DECIMATED]);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
